// ===== rtl/lfca_pkg.sv =====
// ----------------------------------------------------------------------------
// lfca_pkg: shared types and constants
// Request codes, status codes and the command word of the LRU tracker.
// ----------------------------------------------------------------------------
package lfca_pkg;

  localparam int FUNC_W     = 2;
  localparam int HANDLE_W   = 4;
  localparam int REQ_W      = 24;
  localparam int OFS_W      = 24;
  localparam int STATUS_W   = 3;
  localparam int LOW_W      = 24;
  localparam int CFG_W      = 25;
  localparam int ALIGN_BYTES = 16;
  localparam int LRU_IDX_W  = 6;

  localparam logic       REG_LOW_MARK  = 1'b0;
  localparam logic       REG_HIGH_MARK = 1'b1;
  localparam logic       KIND_ANSWER   = 1'b0;
  localparam logic       KIND_EVICT    = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC = 2'd0,
    FN_CHECK = 2'd1,
    FN_FREE  = 2'd2,
    FN_FLUSH = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_ALREADY   = 3'd1,
    ST_BAD_SIZE  = 3'd2,
    ST_NO_MEM    = 3'd3,
    ST_NOT_ALLOC = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    LRU_NOP     = 3'd0,
    LRU_CLEAR   = 3'd1,
    LRU_TOUCH   = 3'd2,
    LRU_INSERT  = 3'd3,
    LRU_RELEASE = 3'd4
  } lru_cmd_t;

  typedef struct packed {
    lru_cmd_t               cmd;
    logic [LRU_IDX_W-1:0]   idx;
  } lru_op_t;

endpackage

// ===== rtl/lfca_slot_mem.sv =====
// ----------------------------------------------------------------------------
// lfca_slot_mem: slot range store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lfca_slot_mem #(
  parameter int DEPTH = 16,
  parameter int IW    = 4,
  parameter int AW    = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic [AW-1:0] wstart,
  input  logic [AW:0]   wend,
  input  logic [IW-1:0] raddr,
  output logic [AW-1:0] rstart,
  output logic [AW:0]   rend
);

  logic [AW-1:0] start_mem [DEPTH];
  logic [AW:0]   end_mem   [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      start_mem[waddr] <= wstart;
      end_mem[waddr]   <= wend;
    end
    rstart <= start_mem[raddr];
    rend   <= end_mem[raddr];
  end

endmodule

// ===== rtl/lfca_lru.sv =====
// ----------------------------------------------------------------------------
// lfca_lru: valid bits and recency ranks
// Rank 0 is the most recent entry; all ranks update in parallel per command.
// ----------------------------------------------------------------------------
module lfca_lru
  import lfca_pkg::*;
#(
  parameter  int NUM_HANDLES = 16,
  localparam int IW = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lru_op_t                op,
  output logic [NUM_HANDLES-1:0] valid,
  output logic [IW-1:0]          rank_sel
);

  logic [NUM_HANDLES-1:0] valid_r;
  logic [IW-1:0]          rank_r [NUM_HANDLES];
  logic [IW-1:0]          sidx;

  assign sidx     = op.idx[IW-1:0];
  assign rank_sel = rank_r[sidx];
  assign valid    = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      case (op.cmd)
        LRU_CLEAR:   valid_r       <= '0;
        LRU_INSERT:  valid_r[sidx] <= 1'b1;
        LRU_RELEASE: valid_r[sidx] <= 1'b0;
        default:     valid_r       <= valid_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_HANDLES; j++) begin
      case (op.cmd)
        LRU_INSERT: begin
          if (IW'(j) == sidx) rank_r[j] <= '0;
          else if (valid_r[j]) rank_r[j] <= rank_r[j] + 1'b1;
        end
        LRU_TOUCH: begin
          if (IW'(j) == sidx) rank_r[j] <= '0;
          else if (valid_r[j] && rank_r[j] < rank_sel) rank_r[j] <= rank_r[j] + 1'b1;
        end
        LRU_RELEASE: begin
          if (valid_r[j] && IW'(j) != sidx && rank_r[j] > rank_sel)
            rank_r[j] <= rank_r[j] - 1'b1;
        end
        default: rank_r[j] <= rank_r[j];
      endcase
    end
  end

endmodule

// ===== rtl/lru_first_fit_cache_allocator_core.sv =====
// ----------------------------------------------------------------------------
// lru_first_fit_cache_allocator_core: first-fit byte region allocator
// Places header-padded ranges first-fit between two marks, evicting the least
// recently used entry and reporting it whenever nothing fits (NO_MEM if none).
// ----------------------------------------------------------------------------
// A request takes one transfer in and gives one or more transfers out; the
// block takes no new request until its final answer sits in the output
// register. Flush, free and bad requests go straight to the answer, while a
// check first reads the slot. An alloc runs the shared compare unit over the
// slot store: each pass reads one slot per cycle and pushes the candidate
// position past every overlapping range; a pass without a move places the
// range, with at most NUM_HANDLES + 1 passes, and a candidate that ends past
// the high mark starts an eviction. Each eviction adds an oldest-entry scan,
// a read of that slot and an eviction note, plus a fresh search.
module lru_first_fit_cache_allocator_core
  import lfca_pkg::*;
#(
  parameter  int NUM_HANDLES  = 16,
  parameter  int ADDR_BITS    = 24,
  parameter  int HEADER_BYTES = 64,
  localparam int IW = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [HANDLE_W-1:0] in_handle,
  input  logic [REQ_W-1:0]    in_req_bytes,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_kind,
  output logic [HANDLE_W-1:0] out_handle,
  output logic [OFS_W-1:0]    out_data_offset,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_last,
  // configuration
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  // Arithmetic width: covers a position up to 2^ADDR_BITS plus the largest size.
  localparam int W = ((ADDR_BITS > REQ_W) ? ADDR_BITS : REQ_W) + 2;
  localparam logic [W-1:0] SPACE = {{(W-1){1'b0}}, 1'b1} << ADDR_BITS;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_HANDLES - 1);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_CHKRD  = 10'b00_0000_0010,
    S_CHK    = 10'b00_0000_0100,
    S_PREP   = 10'b00_0000_1000,
    S_FIT    = 10'b00_0001_0000,
    S_ORDER  = 10'b00_0010_0000,
    S_ORDEND = 10'b00_0100_0000,
    S_EVRD   = 10'b00_1000_0000,
    S_NOTE   = 10'b01_0000_0000,
    S_ANS    = 10'b10_0000_0000
  } state_t;

  // Control registers
  state_t        state_r, state_nxt;
  logic [LOW_W-1:0] low_r, low_nxt;
  logic [CFG_W-1:0] high_r, high_nxt;
  logic          a_done_r, a_done_nxt;
  logic          d_vld_r, d_vld_nxt;
  logic          moved_r, moved_nxt;
  logic          found_r, found_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Payload registers
  logic [W-1:0]  size_r, size_nxt;
  logic [W-1:0]  p_r, p_nxt;
  logic [W-1:0]  pend_r, pend_nxt;
  logic [IW-1:0] sel_r, sel_nxt;
  logic [IW-1:0] a_r, a_nxt;
  logic [IW-1:0] d_idx_r, d_idx_nxt;
  logic [IW-1:0] o_r, o_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  logic [IW-1:0] best_rank_r, best_rank_nxt;
  logic [HANDLE_W-1:0] res_handle_r, res_handle_nxt;
  logic [OFS_W-1:0]    res_off_r, res_off_nxt;
  status_t       res_status_r, res_status_nxt;
  logic          out_kind_r, out_kind_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic [OFS_W-1:0]    out_off_r, out_off_nxt;
  status_t       out_status_r, out_status_nxt;
  logic          out_last_r, out_last_nxt;

  // Datapath wires
  logic [W-1:0]        lo_w, hi_w, low_ext, high_ext;
  logic [W-1:0]        sz_sum, sz;
  logic [ADDR_BITS-1:0] q_start;
  logic [ADDR_BITS:0]  q_end;
  logic [W-1:0]        q_start_w, q_end_w;
  logic [OFS_W-1:0]    q_off, p_off;
  logic                hit, at_last, out_free;
  logic [IW-1:0]       hidx, own_idx, rd_addr;
  logic                mem_we;
  lru_op_t             lru_op;
  logic [NUM_HANDLES-1:0] slot_valid;
  logic [IW-1:0]       rank_sel;

  // Clamp the marks to the address space.
  assign low_ext  = W'(low_r);
  assign high_ext = W'(high_r);
  assign lo_w = (low_ext  < SPACE) ? low_ext  : SPACE;
  assign hi_w = (high_ext < SPACE) ? high_ext : SPACE;

  // Header plus payload, rounded up to the alignment.
  assign sz_sum = W'(in_req_bytes) + W'(HEADER_BYTES + ALIGN_BYTES - 1);
  assign sz     = sz_sum & ~W'(ALIGN_BYTES - 1);

  assign q_start_w = W'(q_start);
  assign q_end_w   = W'(q_end);
  assign q_off     = OFS_W'(q_start_w + W'(HEADER_BYTES));
  assign p_off     = OFS_W'(p_r + W'(HEADER_BYTES));

  assign hidx    = IW'(in_handle);
  assign own_idx = IW'(res_handle_r);
  assign rd_addr = (state_r == S_FIT) ? a_r : sel_r;

  // Shared compare unit: the slot read last cycle overlaps [p, pend).
  assign hit     = (state_r == S_FIT) && d_vld_r && slot_valid[d_idx_r] &&
                   (q_start_w < pend_r) && (q_end_w > p_r);
  assign at_last = d_vld_r && (d_idx_r == LAST_IDX);

  assign out_free = !out_valid_r || !out_stall;

  lfca_slot_mem #(
    .DEPTH (NUM_HANDLES),
    .IW    (IW),
    .AW    (ADDR_BITS)
  ) u_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (own_idx),
    .wstart (ADDR_BITS'(p_r)),
    .wend   ((ADDR_BITS + 1)'(pend_r)),
    .raddr  (rd_addr),
    .rstart (q_start),
    .rend   (q_end)
  );

  lfca_lru #(
    .NUM_HANDLES (NUM_HANDLES)
  ) u_lru (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (lru_op),
    .valid    (slot_valid),
    .rank_sel (rank_sel)
  );

  always_comb begin
    state_nxt      = state_r;
    low_nxt        = low_r;
    high_nxt       = high_r;
    a_done_nxt     = a_done_r;
    moved_nxt      = moved_r;
    found_nxt      = found_r;
    size_nxt       = size_r;
    p_nxt          = p_r;
    pend_nxt       = pend_r;
    sel_nxt        = sel_r;
    a_nxt          = a_r;
    o_nxt          = o_r;
    best_idx_nxt   = best_idx_r;
    best_rank_nxt  = best_rank_r;
    res_handle_nxt = res_handle_r;
    res_off_nxt    = res_off_r;
    res_status_nxt = res_status_r;
    lru_op.cmd     = LRU_NOP;
    lru_op.idx     = LRU_IDX_W'(sel_r);
    mem_we         = 1'b0;

    // Issue pipeline: a read issued this cycle returns data next cycle.
    d_vld_nxt = (state_r == S_FIT) && !a_done_r;
    d_idx_nxt = a_r;

    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_handle_nxt = out_handle_r;
    out_off_nxt    = out_off_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    if (cfg_we) begin
      if (cfg_index == REG_LOW_MARK) low_nxt = cfg_wdata[LOW_W-1:0];
      else high_nxt = cfg_wdata;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_handle_nxt = in_handle;
          res_off_nxt    = '0;
          res_status_nxt = ST_OK;
          sel_nxt        = hidx;
          p_nxt          = lo_w;
          size_nxt       = sz;
          state_nxt      = S_ANS;
          if (func_t'(in_func) == FN_FLUSH) begin
            lru_op.cmd = LRU_CLEAR;
          end else if (int'(in_handle) >= NUM_HANDLES) begin
            res_status_nxt = ST_NOT_ALLOC;
          end else begin
            case (func_t'(in_func))
              FN_CHECK: begin
                if (!slot_valid[hidx]) res_status_nxt = ST_NOT_ALLOC;
                else state_nxt = S_CHKRD;
              end
              FN_FREE: begin
                if (!slot_valid[hidx]) begin
                  res_status_nxt = ST_NOT_ALLOC;
                end else begin
                  lru_op.cmd = LRU_RELEASE;
                  lru_op.idx = LRU_IDX_W'(hidx);
                end
              end
              FN_ALLOC: begin
                if (slot_valid[hidx]) res_status_nxt = ST_ALREADY;
                else if (in_req_bytes == '0) res_status_nxt = ST_BAD_SIZE;
                else state_nxt = S_PREP;
              end
              default: res_status_nxt = ST_NOT_ALLOC;
            endcase
          end
        end
      end

      S_CHKRD: state_nxt = S_CHK;

      S_CHK: begin
        lru_op.cmd  = LRU_TOUCH;
        res_off_nxt = q_off;
        state_nxt   = S_ANS;
      end

      S_PREP: begin
        pend_nxt   = p_r + size_r;
        a_nxt      = '0;
        a_done_nxt = 1'b0;
        moved_nxt  = 1'b0;
        state_nxt  = S_FIT;
      end

      S_FIT: begin
        if (!a_done_r) begin
          if (a_r == LAST_IDX) a_done_nxt = 1'b1;
          else a_nxt = a_r + 1'b1;
        end
        // Push the candidate past the overlapping range.
        if (hit) begin
          p_nxt     = q_end_w;
          pend_nxt  = q_end_w + size_r;
          moved_nxt = 1'b1;
        end
        if (at_last) begin
          if (pend_r > hi_w) begin
            // The candidate only grows, so this search cannot succeed.
            o_nxt     = '0;
            found_nxt = 1'b0;
            state_nxt = S_ORDER;
          end else if (hit || moved_r) begin
            a_nxt      = '0;
            a_done_nxt = 1'b0;
            moved_nxt  = 1'b0;
          end else begin
            lru_op.cmd  = LRU_INSERT;
            lru_op.idx  = LRU_IDX_W'(own_idx);
            mem_we      = 1'b1;
            res_off_nxt = p_off;
            state_nxt   = S_ANS;
          end
        end
      end

      S_ORDER: begin
        lru_op.idx = LRU_IDX_W'(o_r);
        if (slot_valid[o_r] && (!found_r || rank_sel > best_rank_r)) begin
          found_nxt     = 1'b1;
          best_idx_nxt  = o_r;
          best_rank_nxt = rank_sel;
        end
        if (o_r == LAST_IDX) state_nxt = S_ORDEND;
        else o_nxt = o_r + 1'b1;
      end

      S_ORDEND: begin
        if (!found_r) begin
          res_status_nxt = ST_NO_MEM;
          res_off_nxt    = '0;
          state_nxt      = S_ANS;
        end else begin
          sel_nxt   = best_idx_r;
          state_nxt = S_EVRD;
        end
      end

      S_EVRD: state_nxt = S_NOTE;

      S_NOTE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_EVICT;
          out_handle_nxt = HANDLE_W'(sel_r);
          out_off_nxt    = q_off;
          out_status_nxt = ST_OK;
          out_last_nxt   = 1'b0;
          lru_op.cmd     = LRU_RELEASE;
          p_nxt          = lo_w;
          state_nxt      = S_PREP;
        end
      end

      S_ANS: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_ANSWER;
          out_handle_nxt = res_handle_r;
          out_off_nxt    = res_off_r;
          out_status_nxt = res_status_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      low_r       <= '0;
      high_r      <= CFG_W'(25'h100_0000);
      a_done_r    <= 1'b1;
      d_vld_r     <= 1'b0;
      moved_r     <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      a_done_r    <= a_done_nxt;
      d_vld_r     <= d_vld_nxt;
      moved_r     <= moved_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r       <= size_nxt;
    p_r          <= p_nxt;
    pend_r       <= pend_nxt;
    sel_r        <= sel_nxt;
    a_r          <= a_nxt;
    d_idx_r      <= d_idx_nxt;
    o_r          <= o_nxt;
    best_idx_r   <= best_idx_nxt;
    best_rank_r  <= best_rank_nxt;
    res_handle_r <= res_handle_nxt;
    res_off_r    <= res_off_nxt;
    res_status_r <= res_status_nxt;
    out_kind_r   <= out_kind_nxt;
    out_handle_r <= out_handle_nxt;
    out_off_r    <= out_off_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Hold requests while a request is in flight.
  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_handle      = out_handle_r;
  assign out_data_offset = out_off_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

endmodule
